// ===== sv/toc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package toc_pkg;

   // Counter geometry
   localparam int CountWidthDefault = 48;
   localparam int CountOutWidth     = 48;
   localparam int NumChannels       = 96;
   localparam int CtxPerGroup       = 16;
   localparam int NumBanks          = 3;
   localparam int BankDepth         = 32;
   localparam int BankAddrWidth     = $clog2(BankDepth);
   localparam int BankSelWidth      = $clog2(NumBanks);
   localparam int ChannelWidth      = 7;
   localparam int CtxWidth          = 4;
   localparam int WeightWidth       = 8;
   localparam int ByteWidth         = 8;

   // Special byte values
   localparam logic [ByteWidth-1:0] NewlineByte = 8'h0A;
   localparam logic [ByteWidth-1:0] ByteA       = 8'h41;
   localparam logic [ByteWidth-1:0] ByteC       = 8'h43;
   localparam logic [ByteWidth-1:0] ByteG       = 8'h47;
   localparam logic [ByteWidth-1:0] ByteT       = 8'h54;

   // Action codes
   localparam logic ActFeed = 1'b0;
   localparam logic ActRead = 1'b1;

   // First channel of the A/T centre groups
   localparam logic [ChannelWidth-1:0] AtGroupBase = ChannelWidth'(3 * CtxPerGroup);

   typedef enum logic [2:0] {
      BASE_N = 3'd0,
      BASE_A = 3'd1,
      BASE_C = 3'd2,
      BASE_G = 3'd3,
      BASE_T = 3'd4
   } base_type;

   typedef struct packed {
      logic                    action;
      logic [ByteWidth-1:0]    base_byte;
      logic [WeightWidth-1:0]  weight;
      logic                    restart;
      logic [ChannelWidth-1:0] read_channel;
   } toc_req_type;

   typedef struct packed {
      logic [CountOutWidth-1:0] count;
      logic                     counted;
      logic [CtxWidth-1:0]      context_res;
      logic [ChannelWidth-1:0]  first_channel;
   } toc_rsp_type;

   // Decoded operation handed from the context stage to the counter pipeline
   typedef struct packed {
      logic                     rd;
      logic                     rd_ok;
      logic [BankSelWidth-1:0]  rd_bank;
      logic                     upd;
      logic [BankAddrWidth-1:0] addr;
      logic [WeightWidth-1:0]   weight;
      logic [CtxWidth-1:0]      ctx;
      logic [ChannelWidth-1:0]  first_channel;
   } toc_op_type;

   function automatic base_type byte_to_base(input logic [ByteWidth-1:0] b);
      base_type code;
      case (b)
         ByteA:   code = BASE_A;
         ByteC:   code = BASE_C;
         ByteG:   code = BASE_G;
         ByteT:   code = BASE_T;
         default: code = BASE_N;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== sv/toc_bank.sv =====
`timescale 1ns / 1ps
`default_nettype none

module toc_bank #(
   parameter int COUNT_WIDTH = toc_pkg::CountWidthDefault
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              rd_en,
   input  wire logic [toc_pkg::BankAddrWidth-1:0] rd_addr,
   output logic [COUNT_WIDTH-1:0]                 rd_data,
   input  wire logic                              wr_en,
   input  wire logic [toc_pkg::BankAddrWidth-1:0] wr_addr,
   input  wire logic [COUNT_WIDTH-1:0]            wr_data
);
   import toc_pkg::*;

   logic [COUNT_WIDTH-1:0] mem_ff [BankDepth];
   logic [BankDepth-1:0]   valid_ff;
   logic [BankDepth-1:0]   valid_in;
   logic [COUNT_WIDTH-1:0] rd_word_ff;
   logic                   rd_hit_ff;

   // Mark an entry as holding a real count once written
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= mem_ff[rd_addr];
      end
   end

   // Unwritten entries read as zero
   assign rd_data = rd_hit_ff ? rd_word_ff : '0;

endmodule

`default_nettype wire

// ===== sv/toc_context.sv =====
`timescale 1ns / 1ps
`default_nettype none

module toc_context (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire toc_pkg::toc_req_type req,
   output toc_pkg::toc_op_type       op
);
   import toc_pkg::*;

   base_type left_ff, left_in;
   base_type middle_ff, middle_in;
   base_type l, m, r;
   logic     is_newline;
   logic     full_triplet;
   logic     at_centre;
   logic [2:0] grp;

   always_comb begin
      // Start from the current context, cleared on region restart
      l = req.restart ? BASE_N : left_ff;
      m = req.restart ? BASE_N : middle_ff;
      r = byte_to_base(req.base_byte);
      is_newline   = (req.base_byte == NewlineByte);
      full_triplet = (l != BASE_N) && (m != BASE_N) && (r != BASE_N);
      at_centre    = (m == BASE_A) || (m == BASE_T);
      grp          = req.read_channel[ChannelWidth-1 -: 3];

      left_in   = left_ff;
      middle_in = middle_ff;
      op        = '0;
      op.weight = req.weight;

      if (req.action == ActRead) begin
         // Locate the bank and row of the requested channel
         op.rd    = 1'b1;
         op.rd_ok = (req.read_channel < ChannelWidth'(NumChannels));
         op.addr  = {(grp >= 3'd3), req.read_channel[CtxWidth-1:0]};
         case (grp)
            3'd1, 3'd4: op.rd_bank = BankSelWidth'(1);
            3'd2, 3'd5: op.rd_bank = BankSelWidth'(2);
            default:    op.rd_bank = BankSelWidth'(0);
         endcase
      end else begin
         left_in   = l;
         middle_in = m;
         if (!is_newline) begin
            // Shift the new base in
            left_in   = m;
            middle_in = r;
            if (full_triplet) begin
               op.upd = 1'b1;
               if ((m == BASE_C) || (m == BASE_T)) begin
                  op.ctx = {2'(l - BASE_A), 2'(r - BASE_A)};
               end else begin
                  op.ctx = {2'(BASE_T - r), 2'(BASE_T - l)};
               end
               op.addr          = {at_centre, op.ctx};
               op.first_channel = at_centre ? (AtGroupBase + ChannelWidth'(op.ctx))
                                            : ChannelWidth'(op.ctx);
            end
         end
      end
   end

   // Hold the two previous bases
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= BASE_N;
         middle_ff <= BASE_N;
      end else if (accept) begin
         left_ff   <= left_in;
         middle_ff <= middle_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/trinucleotide_opportunity_counter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Trinucleotide opportunity counter. Takes one transaction per clock while
// req_stall is low: a base byte (newline skipped, anything but A/C/G/T is N) or a
// read of one of 96 saturating counters. Each base that completes a known triplet
// adds its weight to three channels of its pyrimidine-folded context. Every
// transaction yields exactly one response transaction, registered in the read and
// output stages. The counters live in three 32-entry banks, one per channel of a
// triple, read on acceptance and written back from the read stage; the last write
// is forwarded so back-to-back hits on the same row see fresh data. Per-row valid
// bits clear the counts at reset at once, so the block takes transactions from the
// first cycle after reset. Reads above channel 95 return zero.
module trinucleotide_opportunity_counter #(
   parameter int COUNT_WIDTH = toc_pkg::CountWidthDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire toc_pkg::toc_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output toc_pkg::toc_rsp_type      rsp_data
);
   import toc_pkg::*;

   localparam int SumWidth = COUNT_WIDTH + 1;

   toc_op_type op;
   toc_op_type s1_op_ff;
   logic       s1_valid_ff;
   logic       rsp_valid_ff;
   toc_rsp_type rsp_data_ff, rsp_data_in;

   logic en_out, en_s1, s1_move, accept, wr_en;

   logic [COUNT_WIDTH-1:0]   rd_data  [NumBanks];
   logic [COUNT_WIDTH-1:0]   cur      [NumBanks];
   logic [COUNT_WIDTH-1:0]   wr_data  [NumBanks];
   logic [SumWidth-1:0]      sum      [NumBanks];
   logic [COUNT_WIDTH-1:0]   fwd_data_ff [NumBanks];
   logic [BankAddrWidth-1:0] fwd_addr_ff;
   logic                     fwd_valid_ff;
   logic                     fwd_hit;
   logic [COUNT_WIDTH-1:0]   rd_sel;
   logic [63:0]              count_ext;

   // Advance control: output register, then the read stage
   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && en_out;
   assign en_s1     = !s1_valid_ff || en_out;
   assign req_stall = !en_s1;
   assign accept    = req_valid && en_s1;
   assign wr_en     = s1_move && s1_op_ff.upd;

   toc_context u_context (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .op     (op)
   );

   assign fwd_hit = fwd_valid_ff && (fwd_addr_ff == s1_op_ff.addr);

   // One bank per channel of a triple; all three share the row address
   for (genvar b = 0; b < NumBanks; b++) begin : g_bank
      toc_bank #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_bank (
         .clock   (clock),
         .reset   (reset),
         .rd_en   (accept),
         .rd_addr (op.addr),
         .rd_data (rd_data[b]),
         .wr_en   (wr_en),
         .wr_addr (s1_op_ff.addr),
         .wr_data (wr_data[b])
      );

      // Take the forwarded value when the last write hit this row
      assign cur[b] = fwd_hit ? fwd_data_ff[b] : rd_data[b];

      // Saturating add of the weight
      assign sum[b]     = {1'b0, cur[b]} + SumWidth'(s1_op_ff.weight);
      assign wr_data[b] = sum[b][COUNT_WIDTH] ? '1 : sum[b][COUNT_WIDTH-1:0];
   end

   // Select the bank that holds the read channel
   always_comb begin
      case (s1_op_ff.rd_bank)
         BankSelWidth'(1): rd_sel = cur[1];
         BankSelWidth'(2): rd_sel = cur[2];
         default:          rd_sel = cur[0];
      endcase
   end

   assign count_ext = 64'((s1_op_ff.rd && s1_op_ff.rd_ok) ? rd_sel : '0);

   always_comb begin
      rsp_data_in.count         = count_ext[CountOutWidth-1:0];
      rsp_data_in.counted       = s1_op_ff.upd;
      rsp_data_in.context_res   = s1_op_ff.ctx;
      rsp_data_in.first_channel = s1_op_ff.first_channel;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (en_s1) begin
            s1_valid_ff <= accept;
         end
         if (en_out) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (wr_en) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   // Payload registers: read stage, forward copy, output
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff <= op;
      end
      if (wr_en) begin
         fwd_addr_ff <= s1_op_ff.addr;
         for (int b = 0; b < NumBanks; b++) begin
            fwd_data_ff[b] <= wr_data[b];
         end
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
